FILE: rtl/fol_pkg.sv
// Shared types, constants and helpers for the frequency ordered list.
package fol_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;

  // Index of a cell, and a fill level that can also hold ENTRIES itself
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int USED_W = $clog2(ENTRIES + 1);

  localparam int CMD_W    = 2;
  localparam int KEY_IO_W = 16;
  localparam int CNT_IO_W = 16;
  localparam int STAT_W   = 2;
  localparam int MATCH_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_ACCESS = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    key_t   key;
    count_t count;
  } slot_t;

  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_APPEND,
    SEL_BUMP,
    SEL_NEXT,
    SEL_PREV,
    SEL_HEAD
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
    key_t      key;
  } cell_ctl_t;

  typedef struct packed {
    logic [STAT_W-1:0]          status;
    logic                       hit;
    logic [MATCH_W-1:0]         match_count;
    logic signed [KEY_IO_W-1:0] entry_key;
    logic [CNT_IO_W-1:0]        entry_count;
    logic                       last;
  } res_t;

  // Sign-extend the request key, then keep KEY_BITS bits
  function automatic key_t to_key(input logic signed [KEY_IO_W-1:0] k);
    logic [KEY_BITS+KEY_IO_W-1:0] ext;
    ext = {{KEY_BITS{k[KEY_IO_W-1]}}, k};
    return ext[KEY_BITS-1:0];
  endfunction

  function automatic logic [KEY_IO_W-1:0] key_out(input key_t k);
    logic [KEY_BITS+KEY_IO_W-1:0] z;
    z = {{KEY_IO_W{1'b0}}, k};
    return z[KEY_IO_W-1:0];
  endfunction

  function automatic logic [CNT_IO_W-1:0] count_out(input count_t c);
    logic [COUNT_BITS+CNT_IO_W-1:0] z;
    z = {{CNT_IO_W{1'b0}}, c};
    return z[CNT_IO_W-1:0];
  endfunction

  function automatic logic [MATCH_W-1:0] match_out(input logic [USED_W-1:0] m);
    logic [USED_W+MATCH_W-1:0] z;
    z = {{MATCH_W{1'b0}}, m};
    return z[MATCH_W-1:0];
  endfunction

  function automatic res_t mk_res(input status_t st, input logic hit,
                                  input logic [MATCH_W-1:0] mc,
                                  input logic [KEY_IO_W-1:0] ek,
                                  input logic [CNT_IO_W-1:0] ec, input logic last);
    res_t r;
    r.status      = st;
    r.hit         = hit;
    r.match_count = mc;
    r.entry_key   = ek;
    r.entry_count = ec;
    r.last        = last;
    return r;
  endfunction

endpackage

FILE: rtl/fol_intf.sv
// Request and result channel interfaces for the frequency ordered list.
interface fol_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [fol_pkg::CMD_W-1:0]                command;
  logic signed [fol_pkg::KEY_IO_W-1:0]      key;

  modport source(output valid, command, key, input ready);
  modport sink(input valid, command, key, output ready);
endinterface

interface fol_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [fol_pkg::STAT_W-1:0]               status;
  logic                                     hit;
  logic [fol_pkg::MATCH_W-1:0]              match_count;
  logic signed [fol_pkg::KEY_IO_W-1:0]      entry_key;
  logic [fol_pkg::CNT_IO_W-1:0]             entry_count;
  logic                                     last;

  modport source(output valid, status, hit, match_count, entry_key, entry_count, last,
                 input ready);
  modport sink(input valid, status, hit, match_count, entry_key, entry_count, last,
               output ready);
endinterface

FILE: rtl/fol_cell.sv
// One table slot: key and count, appended, loaded from a neighbour or from cell 0, or bumped in place.
module fol_cell (
  input  logic                clk,
  input  fol_pkg::cell_ctl_t  ctl,
  input  fol_pkg::slot_t      prev,
  input  fol_pkg::slot_t      next,
  input  fol_pkg::slot_t      head,
  output fol_pkg::slot_t      slot,
  output logic                match
);

  fol_pkg::slot_t slot_r;
  fol_pkg::slot_t slot_nxt;

  assign match = (slot_r.key == ctl.key);
  assign slot  = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl.sel)
      fol_pkg::SEL_HOLD:   slot_nxt = slot_r;
      fol_pkg::SEL_APPEND: begin
        slot_nxt.key   = ctl.key;
        slot_nxt.count = '0;
      end
      fol_pkg::SEL_BUMP: begin
        // saturating bump; still reported as a match by the caller
        if (match && slot_r.count != fol_pkg::COUNT_MAX) begin
          slot_nxt.count = slot_r.count + fol_pkg::count_t'(1);
        end
      end
      fol_pkg::SEL_NEXT:   slot_nxt = next;
      fol_pkg::SEL_PREV:   slot_nxt = prev;
      fol_pkg::SEL_HEAD:   slot_nxt = head;
      default:             slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

FILE: rtl/frequency_ordered_list.sv
// Top level of the frequency ordered list: cell row, sort sequencer and result register.
//
//  channel | dir | signals                                              | transfer
//  --------+-----+------------------------------------------------------+----------------
//  in_chan | in  | command[1:0], key[15:0]                              | valid & ready
//  out_chan| out | status, hit, match_count, entry_key, entry_count,last| valid & ready
//
// Clear and append: the result is registered in the cycle after the request.
// Access: bump on the request edge, then ENTRIES odd-even transposition rounds
//   over the cell row; the result is registered as the last round ends.
// Dump: the used cells rotate through cell 0, one entry per cycle the output is free.
// A new request is taken only between commands, while the result register is free
//   or being drained. Synchronous active-low reset empties the table.
module frequency_ordered_list (
  input  logic   clk,
  input  logic   rst_n,
  fol_in_if.sink     in_chan,
  fol_out_if.source  out_chan
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_DUMP
  } state_t;

  state_t                        state_r;
  logic [fol_pkg::USED_W-1:0]    used_r;
  logic [fol_pkg::USED_W-1:0]    left_r;
  logic [fol_pkg::USED_W-1:0]    mcount_r;
  logic [fol_pkg::IDX_W-1:0]     rnd_r;
  logic [fol_pkg::ENTRIES-1:0]   match_r;
  logic                          out_valid_r;
  fol_pkg::res_t                 out_r;

  fol_pkg::slot_t                slots   [fol_pkg::ENTRIES];
  fol_pkg::cell_ctl_t            ctls    [fol_pkg::ENTRIES];
  logic [fol_pkg::ENTRIES-1:0]   cell_match;
  logic [fol_pkg::ENTRIES-1:0]   in_use;
  logic [fol_pkg::ENTRIES-1:0]   swap;
  logic [fol_pkg::ENTRIES-1:0]   swap_prev;
  logic [fol_pkg::USED_W-1:0]    mcount_fin;

  logic          out_free;
  logic          in_acc;
  fol_pkg::cmd_t cmd;
  fol_pkg::key_t in_key;
  logic          sort_done;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign cmd       = fol_pkg::cmd_t'(in_chan.command);
  assign in_key    = fol_pkg::to_key(in_chan.key);
  assign sort_done = (rnd_r == fol_pkg::IDX_W'(fol_pkg::ENTRIES - 1));
  assign mcount_fin = mcount_r + fol_pkg::USED_W'(match_r[0]);

  assign swap[fol_pkg::ENTRIES-1] = 1'b0;
  assign swap_prev = {swap[fol_pkg::ENTRIES-2:0], 1'b0};

  for (genvar j = 0; j < fol_pkg::ENTRIES; j++) begin : g_cell
    fol_pkg::slot_t prev_w;
    fol_pkg::slot_t next_w;

    assign in_use[j] = fol_pkg::USED_W'(j) < used_r;

    if (j == 0) begin : g_first
      assign prev_w = slots[0];
    end else begin : g_mid
      assign prev_w = slots[j-1];
    end

    if (j == fol_pkg::ENTRIES - 1) begin : g_tail
      assign next_w = slots[0];
    end else begin : g_body
      // only pairs inside the used part of the row take part; strict compare keeps order stable
      assign swap[j] = in_use[j+1] && (rnd_r[0] == 1'(j % 2)) &&
                       (slots[j].count < slots[j+1].count);
      assign next_w = slots[j+1];
    end

    always_comb begin
      ctls[j].key = in_key;
      ctls[j].sel = fol_pkg::SEL_HOLD;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == fol_pkg::CMD_APPEND && used_r == fol_pkg::USED_W'(j)) begin
              ctls[j].sel = fol_pkg::SEL_APPEND;
            end else if (cmd == fol_pkg::CMD_ACCESS && in_use[j]) begin
              ctls[j].sel = fol_pkg::SEL_BUMP;
            end
          end
        end
        S_SORT: begin
          if (swap[j]) begin
            ctls[j].sel = fol_pkg::SEL_NEXT;
          end else if (swap_prev[j]) begin
            ctls[j].sel = fol_pkg::SEL_PREV;
          end
        end
        S_DUMP: begin
          // rotate the used part left; cell 0 wraps round to the last used cell
          if (out_free && in_use[j]) begin
            ctls[j].sel = (fol_pkg::USED_W'(j + 1) == used_r) ? fol_pkg::SEL_HEAD
                                                               : fol_pkg::SEL_NEXT;
          end
        end
        default: ctls[j].sel = fol_pkg::SEL_HOLD;
      endcase
    end

    fol_cell u_cell (
      .clk   (clk),
      .ctl   (ctls[j]),
      .prev  (prev_w),
      .next  (next_w),
      .head  (slots[0]),
      .slot  (slots[j]),
      .match (cell_match[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rnd_r    <= '0;
            mcount_r <= '0;
            case (cmd)
              fol_pkg::CMD_CLEAR: begin
                used_r      <= '0;
                out_valid_r <= 1'b1;
                out_r       <= fol_pkg::mk_res(fol_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
              end
              fol_pkg::CMD_APPEND: begin
                out_valid_r <= 1'b1;
                if (used_r == fol_pkg::USED_W'(fol_pkg::ENTRIES)) begin
                  out_r <= fol_pkg::mk_res(fol_pkg::ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  used_r <= used_r + fol_pkg::USED_W'(1);
                  out_r  <= fol_pkg::mk_res(fol_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
                end
              end
              fol_pkg::CMD_ACCESS: begin
                match_r <= cell_match & in_use;
                state_r <= S_SORT;
              end
              fol_pkg::CMD_DUMP: begin
                if (used_r == '0) begin
                  out_valid_r <= 1'b1;
                  out_r <= fol_pkg::mk_res(fol_pkg::ST_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  left_r  <= used_r;
                  state_r <= S_DUMP;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SORT: begin
          // match flags drain one a round into the running count
          rnd_r    <= rnd_r + fol_pkg::IDX_W'(1);
          match_r  <= match_r >> 1;
          mcount_r <= mcount_fin;
          if (sort_done) begin
            out_valid_r <= 1'b1;
            out_r <= fol_pkg::mk_res(fol_pkg::ST_OK, mcount_fin != '0,
                                     fol_pkg::match_out(mcount_fin), '0, '0, 1'b1);
            state_r <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r <= fol_pkg::mk_res(fol_pkg::ST_OK, 1'b0, '0,
                                     fol_pkg::key_out(slots[0].key),
                                     fol_pkg::count_out(slots[0].count),
                                     left_r == fol_pkg::USED_W'(1));
            left_r <= left_r - fol_pkg::USED_W'(1);
            if (left_r == fol_pkg::USED_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.hit         = out_r.hit;
  assign out_chan.match_count = out_r.match_count;
  assign out_chan.entry_key   = out_r.entry_key;
  assign out_chan.entry_count = out_r.entry_count;
  assign out_chan.last        = out_r.last;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= fol_pkg::USED_W'(fol_pkg::ENTRIES))
    else $error("fill level beyond table size");

  a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_chan.ready)
    else $error("request taken while a command is in progress");

  a_sort_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SORT && sort_done |=> out_valid_r && out_r.last && state_r == S_IDLE)
    else $error("access finished without a result");

  a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |=> $stable(used_r))
    else $error("fill level changed during dump");

  a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> left_r != '0 && left_r <= used_r)
    else $error("dump entry count out of range");

endmodule

FILE: tb/fol_checker.sv
// Checker for the frequency ordered list: predicts each request's results and compares them.
module fol_checker (
  input  logic clk,
  input  logic rst_n,
  fol_in_if    in_mon,
  fol_out_if   out_mon,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  fol_pkg::key_t   row_key [fol_pkg::ENTRIES];
  fol_pkg::count_t row_cnt [fol_pkg::ENTRIES];
  int              rows_used;
  fol_pkg::res_t   due_results[$];

  task automatic report(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    errors++;
  endtask

  task automatic field_check(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Stable: an entry only moves past a strictly smaller count
  function automatic void reorder_by_count();
    fol_pkg::key_t   k;
    fol_pkg::count_t c;
    int              j;
    for (int i = 1; i < rows_used; i++) begin
      k = row_key[i];
      c = row_cnt[i];
      j = i;
      while (j > 0 && row_cnt[j-1] < c) begin
        row_key[j] = row_key[j-1];
        row_cnt[j] = row_cnt[j-1];
        j--;
      end
      row_key[j] = k;
      row_cnt[j] = c;
    end
  endfunction

  function automatic void predict_results(fol_pkg::cmd_t cmd, fol_pkg::key_t k);
    fol_pkg::res_t r;
    int            hits;
    r      = '0;
    r.last = 1'b1;
    case (cmd)
      fol_pkg::CMD_CLEAR: begin
        rows_used = 0;
        due_results.push_back(r);
      end
      fol_pkg::CMD_APPEND: begin
        if (rows_used >= fol_pkg::ENTRIES) begin
          r.status = fol_pkg::ST_FULL;
        end else begin
          row_key[rows_used] = k;
          row_cnt[rows_used] = '0;
          rows_used++;
        end
        due_results.push_back(r);
      end
      fol_pkg::CMD_ACCESS: begin
        hits = 0;
        for (int i = 0; i < rows_used; i++) begin
          if (row_key[i] == k) begin
            hits++;
            if (row_cnt[i] != fol_pkg::COUNT_MAX) row_cnt[i]++;
          end
        end
        reorder_by_count();
        r.hit         = (hits != 0);
        r.match_count = fol_pkg::MATCH_W'(hits);
        due_results.push_back(r);
      end
      default: begin
        if (rows_used == 0) begin
          r.status = fol_pkg::ST_EMPTY;
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < rows_used; i++) begin
            r.last        = (i == rows_used - 1);
            r.entry_key   = row_key[i];
            r.entry_count = row_cnt[i];
            due_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    fol_pkg::res_t want;
    if (!rst_n) begin
      rows_used = 0;
      errors    = 0;
      due_results.delete();
    end else begin
      // results first: one arriving now belongs to an earlier request
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          report("result with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          field_check("status", out_mon.status, want.status);
          field_check("hit", out_mon.hit, want.hit);
          field_check("match_count", out_mon.match_count, want.match_count);
          field_check("entry_key", out_mon.entry_key, want.entry_key);
          field_check("entry_count", out_mon.entry_count, want.entry_count);
          field_check("last", out_mon.last, want.last);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_results(fol_pkg::cmd_t'(in_mon.command), fol_pkg::key_t'(in_mon.key));
    end
    pending = due_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the frequency ordered list testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQS = 280;
  localparam int DEAD_LIMIT  = 2000;
  localparam int MAX_GAP     = 11;
  localparam int POOL_SIZE   = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  int   errors;
  int   pending;
  int   rx_hold;
  int   rx_draw;
  int   dead_cycles;
  fol_pkg::key_t key_pool [POOL_SIZE];

  fol_in_if  req_chan();
  fol_out_if res_chan();

  frequency_ordered_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  fol_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (req_chan),
    .out_mon (res_chan),
    .errors  (errors),
    .pending (pending)
  );

  always #4ns clk = ~clk;

  // Result side: random stall before each result, none while no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
      rx_hold        <= 0;
    end else if (res_chan.valid && res_chan.ready) begin
      rx_draw = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      res_chan.ready <= (rx_draw == 0);
      rx_hold        <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else if (!res_chan.ready) begin
      if (rx_hold == 0) res_chan.ready <= 1'b1;
      else rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_chan.valid && req_chan.ready) || (res_chan.valid && res_chan.ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= DEAD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  function automatic fol_pkg::key_t pick_key();
    if ($urandom_range(0, 3) == 0) return fol_pkg::key_t'($urandom());
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_req(fol_pkg::cmd_t cmd, fol_pkg::key_t k);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid   <= 1'b1;
    req_chan.command <= cmd;
    req_chan.key     <= k;
    do @(posedge clk); while (!req_chan.ready);
  endtask

  task automatic wait_for_results();
    req_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int            roll;
    fol_pkg::key_t sat_key;
    rst_n            <= 1'b0;
    no_idle          <= 1'b0;
    req_chan.valid   <= 1'b0;
    req_chan.command <= fol_pkg::CMD_CLEAR;
    req_chan.key     <= '0;
    key_pool = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, fol_pkg::key_t'($urandom()),
                 fol_pkg::key_t'($urandom())};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_req(fol_pkg::CMD_DUMP, pick_key());    // dump of an empty table
    send_req(fol_pkg::CMD_ACCESS, 16'h0000);    // access with nothing stored
    send_req(fol_pkg::CMD_APPEND, 16'h7FFF);
    send_req(fol_pkg::CMD_APPEND, 16'h8000);
    send_req(fol_pkg::CMD_APPEND, 16'h0000);
    send_req(fol_pkg::CMD_APPEND, 16'hFFFF);
    send_req(fol_pkg::CMD_ACCESS, 16'hFFFF);
    send_req(fol_pkg::CMD_ACCESS, 16'h8000);
    send_req(fol_pkg::CMD_APPEND, 16'hFFFF);
    send_req(fol_pkg::CMD_ACCESS, 16'hFFFF);    // two copies of the key
    send_req(fol_pkg::CMD_ACCESS, 16'h1234);    // miss on a populated table
    send_req(fol_pkg::CMD_DUMP, 16'hFFFF);
    repeat (fol_pkg::ENTRIES - 5) send_req(fol_pkg::CMD_APPEND, pick_key());
    send_req(fol_pkg::CMD_APPEND, 16'h7FFF);    // table full
    send_req(fol_pkg::CMD_DUMP, 16'h0000);
    send_req(fol_pkg::CMD_CLEAR, 16'hFFFF);
    send_req(fol_pkg::CMD_DUMP, 16'h0000);

    // two copies of one key, accessed flat out with no stalls
    sat_key = pick_key();
    send_req(fol_pkg::CMD_APPEND, sat_key);
    send_req(fol_pkg::CMD_APPEND, sat_key);
    send_req(fol_pkg::CMD_APPEND, ~sat_key);
    no_idle <= 1'b1;
    wait_for_results();
    repeat (8) send_req(fol_pkg::CMD_ACCESS, sat_key);
    send_req(fol_pkg::CMD_ACCESS, ~sat_key);
    send_req(fol_pkg::CMD_DUMP, 16'h0000);
    send_req(fol_pkg::CMD_CLEAR, 16'h0000);
    no_idle <= 1'b0;
    wait_for_results();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 48 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQS / 2) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 4) send_req(fol_pkg::CMD_CLEAR, pick_key());
      else if (roll < 46) send_req(fol_pkg::CMD_APPEND, pick_key());
      else if (roll < 86) send_req(fol_pkg::CMD_ACCESS, pick_key());
      else send_req(fol_pkg::CMD_DUMP, pick_key());
    end

    wait_for_results();
    repeat (fol_pkg::ENTRIES + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
